### rtl/ktc_pkg.sv
package ktc_pkg;

  localparam int NUM_KEYS    = 26;
  localparam int COORD_W     = 12;
  localparam int RANGE_UNITS = 50;

  localparam int FUNC_W    = 2;
  localparam int LETTER_W  = 5;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int DIST_W    = 13;
  localparam int KIND_W    = 2;

  localparam int KIDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int QBITS   = $clog2(RANGE_UNITS + 1);
  localparam int NUM_W   = COORD_W + QBITS;
  localparam int LIM_W   = CFG_W + $clog2(RANGE_UNITS + 2);
  localparam int CMP_W   = (NUM_W > LIM_W) ? NUM_W : LIM_W;
  localparam int MV_W    = ((COORD_W > CFG_W) ? COORD_W : CFG_W) + 1;
  localparam int SQ_W    = 2 * QBITS + 1;
  localparam int STEP_W  = $clog2(QBITS + 2);

  localparam int CMDQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 2;

  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TOUCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXACT = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MOVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL  = 2'd2;

  localparam logic [CFG_W-1:0] MOVE_RST  = 10'd8;
  localparam logic [CFG_W-1:0] STILL_RST = 10'd2;
  localparam logic [CFG_W-1:0] EXCL_RST  = 10'd50;

  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STILL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PERFECT = 2'd2;

  typedef enum logic [1:0] {
    OP_SET,
    OP_TOUCH,
    OP_EXACT,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [KIDX_W-1:0]  idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cmd_t;

  typedef struct packed {
    logic [LETTER_W-1:0] key_index;
    logic                in_range;
    logic [DIST_W-1:0]   distance;
    logic                move_up;
    logic                move_down;
    logic                move_left;
    logic                move_right;
    logic [KIND_W-1:0]   move_kind;
    logic                last;
  } res_t;

endpackage

### rtl/key_touch_classifier.sv
// Key touch classifier.
// Input queue side: drive func_i, letter_i, pos_x_i, pos_y_i and raise push;
// a beat is taken when push is high and full is low. A four-deep command
// queue sits behind the decoder, so items are taken while earlier ones run.
// Set key and clear history give no result; an exact letter gives one
// result; a touch gives one result per key in key order, last set on the
// final one. Set and exact with a letter outside the table are dropped.
// Result side: the oldest result is on the ports while empty is low and is
// taken on pop. A two-deep result queue lets the engine run ahead by two.
// A command leaves the queue while the engine is idle and the result queue
// is not full. A touch starts in the idle state; per key, the load state
// reads and range-checks the key table, the divide state runs when the key
// is in range (six quotient bits, two a cycle), and the push state posts
// the result. Config writes (cfg_ready_o always high) are for the user to
// make only while the block is idle; the block does not enforce this.
// Reset empties both queues, zeroes the key table and history, and loads
// the registers with 8, 2 and 50. A stalled receiver holds the engine.
module key_touch_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [ktc_pkg::FUNC_W-1:0]    func_i,
  input  logic [ktc_pkg::LETTER_W-1:0]  letter_i,
  input  logic [ktc_pkg::COORD_W-1:0]   pos_x_i,
  input  logic [ktc_pkg::COORD_W-1:0]   pos_y_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [ktc_pkg::LETTER_W-1:0]  key_index_o,
  output logic                          in_range_o,
  output logic [ktc_pkg::DIST_W-1:0]    distance_o,
  output logic                          move_up_o,
  output logic                          move_down_o,
  output logic                          move_left_o,
  output logic                          move_right_o,
  output logic [ktc_pkg::KIND_W-1:0]    move_kind_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ktc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ktc_pkg::CFG_W-1:0]     cfg_data_i
);
  import ktc_pkg::*;

  logic q_full, q_push, q_empty, q_pop;
  cmd_t q_in, q_out;
  res_t res;

  assign cfg_ready_o = 1'b1;

  ktc_front u_front (
    .push     (push),
    .full     (full),
    .func_i   (func_i),
    .letter_i (letter_i),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_in)
  );

  ktc_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_out)
  );

  ktc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_empty_i (q_empty),
    .cmd_i       (q_out),
    .cmd_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign key_index_o  = res.key_index;
  assign in_range_o   = res.in_range;
  assign distance_o   = res.distance;
  assign move_up_o    = res.move_up;
  assign move_down_o  = res.move_down;
  assign move_left_o  = res.move_left;
  assign move_right_o = res.move_right;
  assign move_kind_o  = res.move_kind;
  assign last_o       = res.last;

endmodule

### rtl/ktc_front.sv
module ktc_front (
  input  logic                         push,
  output logic                         full,
  input  logic [ktc_pkg::FUNC_W-1:0]   func_i,
  input  logic [ktc_pkg::LETTER_W-1:0] letter_i,
  input  logic [ktc_pkg::COORD_W-1:0]  pos_x_i,
  input  logic [ktc_pkg::COORD_W-1:0]  pos_y_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output ktc_pkg::cmd_t                q_cmd_o
);
  import ktc_pkg::*;

  logic letter_ok;
  logic keep;

  assign letter_ok = 32'(letter_i) < NUM_KEYS;

  // bad letters for set and exact are dropped here
  always_comb begin
    q_cmd_o.idx = KIDX_W'(letter_i);
    q_cmd_o.x   = pos_x_i;
    q_cmd_o.y   = pos_y_i;
    keep        = 1'b1;
    case (func_i)
      FUNC_SET: begin
        q_cmd_o.op = OP_SET;
        keep       = letter_ok;
      end
      FUNC_TOUCH: q_cmd_o.op = OP_TOUCH;
      FUNC_EXACT: begin
        q_cmd_o.op = OP_EXACT;
        keep       = letter_ok;
      end
      default: q_cmd_o.op = OP_CLEAR;
    endcase
  end

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i && keep;

endmodule

### rtl/ktc_cmdq.sv
module ktc_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ktc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ktc_pkg::cmd_t cmd_o
);
  import ktc_pkg::*;

  localparam int PW = $clog2(CMDQ_DEPTH);
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          mem_q [CMDQ_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == CW'(CMDQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/ktc_back.sv
module ktc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ktc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ktc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          cmd_empty_i,
  input  ktc_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output ktc_pkg::res_t                 res_o
);
  import ktc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  localparam int RPW = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int RCW = $clog2(RESQ_DEPTH + 1);
  localparam logic [KIDX_W-1:0] LAST_K = KIDX_W'(NUM_KEYS - 1);

  logic [CFG_W-1:0]   move_q, still_q, excl_q;
  logic [COORD_W-1:0] key_x_q [NUM_KEYS];
  logic [COORD_W-1:0] key_y_q [NUM_KEYS];
  logic [COORD_W-1:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic               have_prev_q;

  logic [1:0]         state_q, state_d;
  logic [KIDX_W-1:0]  k_q;
  logic [3:0]         mv_q, mv_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic               inr_q;
  logic [NUM_W-1:0]   rx_q, ry_q, ds_q;
  logic [QBITS-1:0]   qx_q, qy_q;
  logic [STEP_W-1:0]  cnt_q;

  res_t               rq_mem_q [RESQ_DEPTH];
  logic [RPW-1:0]     rq_wp_q, rq_rp_q;
  logic [RCW-1:0]     rq_cnt_q;
  logic               rq_full, rq_push, rq_pop;
  res_t               rq_data;

  // motion
  logic [MV_W-1:0]    mx, my, px, py, ms, ss;
  logic [COORD_W-1:0] adx, ady;

  // per key front of the divide
  logic [COORD_W-1:0] kx, ky, magx, magy;
  logic [NUM_W-1:0]   nx, ny, dsh;
  logic [CFG_W-1:0]   dv;
  logic [CMP_W-1:0]   lim;
  logic               unassigned, inr_d;

  // divide steps
  logic [NUM_W-1:0]   rx_s, ry_s, ds_s;
  logic [QBITS-1:0]   qx_s, qy_s;
  logic               div_done;
  logic [SQ_W-1:0]    sq;

  assign rq_full   = rq_cnt_q == RCW'(RESQ_DEPTH);
  assign empty     = rq_cnt_q == '0;
  assign rq_pop    = pop && !empty;
  assign res_o     = rq_mem_q[rq_rp_q];
  assign cmd_pop_o = (state_q == ST_IDLE) && !cmd_empty_i && !rq_full;

  always_comb begin
    mx  = MV_W'(cmd_i.x);
    my  = MV_W'(cmd_i.y);
    px  = MV_W'(prev_x_q);
    py  = MV_W'(prev_y_q);
    ms  = MV_W'(move_q);
    ss  = MV_W'(still_q);
    adx = (cmd_i.x >= prev_x_q) ? cmd_i.x - prev_x_q : prev_x_q - cmd_i.x;
    ady = (cmd_i.y >= prev_y_q) ? cmd_i.y - prev_y_q : prev_y_q - cmd_i.y;
    mv_d   = '0;
    kind_d = KIND_NONE;
    if (have_prev_q) begin
      // order: up, down, left, right
      mv_d[0] = (my + ms < py) && !(my > py + ms);
      mv_d[1] = my > py + ms;
      mv_d[2] = (mx + ms < px) && !(mx > px + ms);
      mv_d[3] = mx > px + ms;
      if (MV_W'(adx) <= ss && MV_W'(ady) <= ss) begin
        mv_d   = '0;
        kind_d = KIND_STILL;
      end
    end
  end

  always_comb begin
    kx         = key_x_q[k_q];
    ky         = key_y_q[k_q];
    magx       = (cur_x_q >= kx) ? cur_x_q - kx : kx - cur_x_q;
    magy       = (cur_y_q >= ky) ? cur_y_q - ky : ky - cur_y_q;
    nx         = NUM_W'(magx) * NUM_W'(RANGE_UNITS);
    ny         = NUM_W'(magy) * NUM_W'(RANGE_UNITS);
    dv         = (excl_q == '0) ? CFG_W'(1) : excl_q;
    lim        = CMP_W'(dv) * CMP_W'(RANGE_UNITS + 1);
    dsh        = NUM_W'(dv) << (QBITS - 1);
    unassigned = (kx == '0) && (ky == '0);
    inr_d      = !unassigned && (CMP_W'(nx) < lim) && (CMP_W'(ny) < lim);
  end

  // two restoring steps a cycle, quotient known to fit QBITS
  always_comb begin
    rx_s = rx_q;
    ry_s = ry_q;
    ds_s = ds_q;
    qx_s = qx_q;
    qy_s = qy_q;
    for (int s = 0; s < 2; s++) begin
      if (int'(cnt_q) + s < QBITS) begin
        if (rx_s >= ds_s) begin
          rx_s = rx_s - ds_s;
          qx_s = QBITS'({qx_s, 1'b1});
        end else begin
          qx_s = QBITS'({qx_s, 1'b0});
        end
        if (ry_s >= ds_s) begin
          ry_s = ry_s - ds_s;
          qy_s = QBITS'({qy_s, 1'b1});
        end else begin
          qy_s = QBITS'({qy_s, 1'b0});
        end
        ds_s = ds_s >> 1;
      end
    end
    div_done = int'(cnt_q) + 2 >= QBITS;
  end

  assign sq = SQ_W'(qx_q) * SQ_W'(qx_q) + SQ_W'(qy_q) * SQ_W'(qy_q);

  always_comb begin
    rq_push = 1'b0;
    rq_data = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          if (cmd_i.op == OP_EXACT) begin
            rq_push            = 1'b1;
            rq_data.key_index  = LETTER_W'(cmd_i.idx);
            rq_data.in_range   = 1'b1;
            rq_data.move_kind  = KIND_PERFECT;
            rq_data.last       = 1'b1;
          end else if (cmd_i.op == OP_TOUCH) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: state_d = inr_d ? ST_DIV : ST_PUSH;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_PUSH;
        end
      end
      default: begin
        if (!rq_full) begin
          rq_push            = 1'b1;
          rq_data.key_index  = LETTER_W'(k_q);
          rq_data.in_range   = inr_q;
          rq_data.distance   = inr_q ? DIST_W'(sq) : '0;
          rq_data.move_up    = mv_q[0];
          rq_data.move_down  = mv_q[1];
          rq_data.move_left  = mv_q[2];
          rq_data.move_right = mv_q[3];
          rq_data.move_kind  = kind_q;
          rq_data.last       = k_q == LAST_K;
          state_d            = (k_q == LAST_K) ? ST_IDLE : ST_LOAD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_q      <= MOVE_RST;
      still_q     <= STILL_RST;
      excl_q      <= EXCL_RST;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      state_q     <= ST_IDLE;
      k_q         <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_x_q[i] <= '0;
        key_y_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MOVE:  move_q  <= cfg_data_i;
          CFG_STILL: still_q <= cfg_data_i;
          CFG_EXCL:  excl_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_pop_o) begin
        case (cmd_i.op)
          OP_SET: begin
            key_x_q[cmd_i.idx] <= cmd_i.x;
            key_y_q[cmd_i.idx] <= cmd_i.y;
          end
          OP_TOUCH: begin
            prev_x_q    <= cmd_i.x;
            prev_y_q    <= cmd_i.y;
            have_prev_q <= 1'b1;
            k_q         <= '0;
          end
          OP_EXACT: begin
            prev_x_q    <= key_x_q[cmd_i.idx];
            prev_y_q    <= key_y_q[cmd_i.idx];
            have_prev_q <= 1'b1;
          end
          default: begin
            prev_x_q    <= '0;
            prev_y_q    <= '0;
            have_prev_q <= 1'b0;
          end
        endcase
      end
      if (state_q == ST_PUSH && !rq_full && k_q != LAST_K) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.op == OP_TOUCH) begin
      cur_x_q <= cmd_i.x;
      cur_y_q <= cmd_i.y;
      mv_q    <= mv_d;
      kind_q  <= kind_d;
    end
    if (state_q == ST_LOAD) begin
      inr_q <= inr_d;
      rx_q  <= nx;
      ry_q  <= ny;
      ds_q  <= dsh;
      qx_q  <= '0;
      qy_q  <= '0;
      cnt_q <= '0;
    end else if (state_q == ST_DIV) begin
      rx_q  <= rx_s;
      ry_q  <= ry_s;
      ds_q  <= ds_s;
      qx_q  <= qx_s;
      qy_q  <= qy_s;
      cnt_q <= cnt_q + STEP_W'(2);
    end
    if (rq_push) begin
      rq_mem_q[rq_wp_q] <= rq_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wp_q  <= '0;
      rq_rp_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      if (rq_push) begin
        rq_wp_q <= rq_wp_q + 1'b1;
      end
      if (rq_pop) begin
        rq_rp_q <= rq_rp_q + 1'b1;
      end
      if (rq_push && !rq_pop) begin
        rq_cnt_q <= rq_cnt_q + 1'b1;
      end else if (rq_pop && !rq_push) begin
        rq_cnt_q <= rq_cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= RCW'(RESQ_DEPTH))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH && !rq_full && k_q == LAST_K) |=> state_q == ST_IDLE)
    else $error("touch sweep did not end after last key");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.in_range) |-> res_o.distance == '0)
    else $error("out of range result with distance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.move_kind == KIND_PERFECT) |->
      (res_o.last && !res_o.move_up && !res_o.move_down &&
       !res_o.move_left && !res_o.move_right))
    else $error("perfect result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> (state_q == ST_DIV || state_q == ST_PUSH))
    else $error("divide left early");

endmodule
